// ===== hdl/spf_pkg.sv =====
// ----------------------------------------------------------------------------
// spf_pkg
// Shared constants, codes and types of the scanline polygon fill unit.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = VIDX_W + 1;
    localparam int MAX_DIM      = 4096;

    localparam int COORD_W = 16;
    localparam int ROW_W   = 12;
    localparam int COL_W   = 12;
    localparam int DIM_W   = 13;
    localparam int FILL_W  = 32;
    localparam int XING_W  = 24;

    // divider widths: numerator is (dx * dy) * 16, denominator dy of the edge
    localparam int NUM_W = 39;
    localparam int DEN_W = 17;
    localparam int QUO_W = 22;
    localparam int REM_W = 17;
    localparam int DIV_STEPS = QUO_W / 2;

    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_RASTER = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_FILL   = 2'd2;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic signed [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [QUO_W-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic                     clear;
        logic                     insert;
        logic                     pop;
        logic signed [XING_W-1:0] value;
    } sort_ctl_t;

endpackage

// ===== hdl/spf_ifs.sv =====
// ----------------------------------------------------------------------------
// spf channel interfaces
// Request channel (vertex loads and row queries) and span result channel.
// ----------------------------------------------------------------------------
interface spf_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           opcode;
    logic signed [spf_pkg::COORD_W-1:0]   vertex_x;
    logic signed [spf_pkg::COORD_W-1:0]   vertex_y;
    logic [spf_pkg::ROW_W-1:0]            row;

    modport source (output valid, opcode, vertex_x, vertex_y, row, input ready);
    modport sink   (input valid, opcode, vertex_x, vertex_y, row, output ready);
endinterface

interface spf_out_if;
    logic                          valid;
    logic                          ready;
    logic [spf_pkg::COL_W-1:0]     span_start;
    logic [spf_pkg::COL_W-1:0]     span_end;
    logic [spf_pkg::FILL_W-1:0]    fill_out;
    logic                          no_span;
    logic                          vertex_overflow;
    logic                          last_span;

    modport source (output valid, span_start, span_end, fill_out, no_span,
                    vertex_overflow, last_span, input ready);
    modport sink   (input valid, span_start, span_end, fill_out, no_span,
                    vertex_overflow, last_span, output ready);
endinterface

// ===== hdl/spf_ram.sv =====
// ----------------------------------------------------------------------------
// spf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/spf_div.sv =====
// ----------------------------------------------------------------------------
// spf_div
// Serial signed divider, two quotient bits a cycle, quotient floored.
// ----------------------------------------------------------------------------
module spf_div (
    input  logic                clk,
    input  logic                rst_n,
    input  spf_pkg::div_req_t   req,
    output spf_pkg::div_rsp_t   rsp
);

    localparam int STEP_W = $clog2(spf_pkg::DIV_STEPS);

    logic                          busy_reg;
    logic                          done_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [spf_pkg::REM_W-1:0]     rem_reg;
    logic [spf_pkg::QUO_W-1:0]     q_reg;
    logic [spf_pkg::DEN_W-1:0]     d_reg;
    logic                          neg_reg;

    logic [spf_pkg::NUM_W-1:0]     nmag;
    logic [spf_pkg::DEN_W-1:0]     dmag;
    logic [spf_pkg::REM_W:0]       r_a;
    logic [spf_pkg::REM_W:0]       r_b;
    logic [spf_pkg::REM_W:0]       s_a;
    logic [spf_pkg::REM_W:0]       s_b;
    logic                          ge_a;
    logic                          ge_b;
    logic [spf_pkg::REM_W-1:0]     rem_a;
    logic [spf_pkg::REM_W-1:0]     rem_b;

    assign nmag = req.num[spf_pkg::NUM_W-1] ? spf_pkg::NUM_W'(-req.num)
                                             : spf_pkg::NUM_W'(req.num);
    assign dmag = req.den[spf_pkg::DEN_W-1] ? spf_pkg::DEN_W'(-req.den)
                                             : spf_pkg::DEN_W'(req.den);

    // two restoring steps, bringing down the next numerator bits from q_reg
    always_comb
    begin
        r_a   = {rem_reg, q_reg[spf_pkg::QUO_W-1]};
        ge_a  = (r_a >= {1'b0, d_reg});
        s_a   = r_a - {1'b0, d_reg};
        rem_a = ge_a ? s_a[spf_pkg::REM_W-1:0] : r_a[spf_pkg::REM_W-1:0];
        r_b   = {rem_a, q_reg[spf_pkg::QUO_W-2]};
        ge_b  = (r_b >= {1'b0, d_reg});
        s_b   = r_b - {1'b0, d_reg};
        rem_b = ge_b ? s_b[spf_pkg::REM_W-1:0] : r_b[spf_pkg::REM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(spf_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            // quotient fits QUO_W bits, so the upper numerator bits start as remainder
            rem_reg <= nmag[spf_pkg::NUM_W-1:spf_pkg::QUO_W];
            q_reg   <= nmag[spf_pkg::QUO_W-1:0];
            d_reg   <= dmag;
            neg_reg <= req.num[spf_pkg::NUM_W-1] ^ req.den[spf_pkg::DEN_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_b;
            q_reg   <= {q_reg[spf_pkg::QUO_W-3:0], ge_a, ge_b};
        end
    end

    // floor: a negative quotient with a remainder drops by one more
    always_comb
    begin
        rsp.done = done_reg;
        if (!neg_reg)
        begin
            rsp.quo = q_reg;
        end
        else if (rem_reg != '0)
        begin
            rsp.quo = ~q_reg;
        end
        else
        begin
            rsp.quo = -q_reg;
        end
    end

endmodule

// ===== hdl/spf_xsort.sv =====
// ----------------------------------------------------------------------------
// spf_xsort
// Crossing list kept in ascending order by insertion; pairs leave from the head.
// ----------------------------------------------------------------------------
module spf_xsort (
    input  logic                                clk,
    input  logic                                rst_n,
    input  spf_pkg::sort_ctl_t                  ctl,
    output logic signed [spf_pkg::XING_W-1:0]   head0,
    output logic signed [spf_pkg::XING_W-1:0]   head1,
    output logic [spf_pkg::VCNT_W-1:0]          count
);

    localparam int N = spf_pkg::MAX_VERTICES;

    logic signed [spf_pkg::XING_W-1:0] ent_reg  [N];
    logic signed [spf_pkg::XING_W-1:0] ent_next [N];
    logic [spf_pkg::VCNT_W-1:0]        cnt_reg;
    logic [N-1:0]                      gt;

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            gt[k] = (spf_pkg::VCNT_W'(k) >= cnt_reg) || (ent_reg[k] > ctl.value);
        end
        for (int k = 0; k < N; k++)
        begin
            ent_next[k] = ent_reg[k];
            if (ctl.insert)
            begin
                // equal values keep their place ahead of the new one
                if (gt[k])
                begin
                    if (k == 0)
                    begin
                        ent_next[k] = ctl.value;
                    end
                    else if (!gt[k-1])
                    begin
                        ent_next[k] = ctl.value;
                    end
                    else
                    begin
                        ent_next[k] = ent_reg[k-1];
                    end
                end
            end
            else if (ctl.pop && (k + 2 < N))
            begin
                ent_next[k] = ent_reg[k+2];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            ent_reg[k] <= ent_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.clear)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.insert)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            cnt_reg <= cnt_reg - spf_pkg::VCNT_W'(2);
        end
    end

    assign head0 = ent_reg[0];
    assign head1 = ent_reg[1];
    assign count = cnt_reg;

endmodule

// ===== hdl/scanline_polygon_fill_unit.sv =====
// ----------------------------------------------------------------------------
// scanline_polygon_fill_unit
// Even-odd scanline fill of one polygon: vertex store, edge walk, sorted spans.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  item    | in  | opcode, vertex_x, vertex_y, row
//  span    | out | span_start, span_end, fill_out, no_span, vertex_overflow,
//          |     | last_span
//  cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
//  A row query reads the vertex RAM once per vertex, and each edge that
//  crosses the row passes through the multiply and the serial divider (2 bits
//  a cycle); spans then leave one crossing pair a cycle while the span
//  channel does not stall, followed by the closing result.
//  No reset sweep: vertex RAM data is only used below the vertex count.
//  A stalled span channel holds the query once the single span buffer is full.
module scanline_polygon_fill_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [spf_pkg::FILL_W-1:0]    cfg_data,
    spf_in_if.sink                        item,
    spf_out_if.source                     span
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FIRST  = 4'd1;
    localparam logic [3:0] S_LOAD   = 4'd2;
    localparam logic [3:0] S_TEST   = 4'd3;
    localparam logic [3:0] S_MUL    = 4'd4;
    localparam logic [3:0] S_DSTART = 4'd5;
    localparam logic [3:0] S_DWAIT  = 4'd6;
    localparam logic [3:0] S_EMIT   = 4'd7;
    localparam logic [3:0] S_FINAL  = 4'd8;

    localparam int CW = spf_pkg::COORD_W;
    localparam int VW = 2 * CW;

    logic [3:0] state_reg, state_next;
    logic [spf_pkg::VCNT_W-1:0] vcount_reg, vcount_next;
    logic ovf_reg, ovf_next;
    logic [spf_pkg::DIM_W-1:0] width_reg, height_reg;
    logic [spf_pkg::FILL_W-1:0] fill_reg;
    logic [16:0] yq_reg, yq_next;
    logic [spf_pkg::VIDX_W-1:0] idx_reg, idx_next;
    logic closing_reg, closing_next;
    logic signed [CW-1:0] fx_reg, fy_reg, px_reg, py_reg;
    logic signed [CW-1:0] fx_next, fy_next, px_next, py_next;
    logic signed [CW-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [CW-1:0] x1_next, y1_next, x2_next, y2_next;
    logic signed [16:0] dx_reg, dx_next, den_reg, den_next;
    logic signed [17:0] dy_reg, dy_next;
    logic signed [34:0] prod_reg;
    logic held_valid_reg, held_valid_next;
    logic [spf_pkg::COL_W-1:0] held_start_reg, held_start_next;
    logic [spf_pkg::COL_W-1:0] held_end_reg, held_end_next;

    logic out_valid_reg;
    logic [spf_pkg::COL_W-1:0] out_start_reg, out_end_reg;
    logic [spf_pkg::FILL_W-1:0] out_fill_reg;
    logic out_none_reg, out_ovf_reg, out_last_reg;

    logic push, push_none, push_last;
    logic [spf_pkg::COL_W-1:0] push_start, push_end;
    logic out_free;
    logic accept;
    logic adv;

    logic ram_we;
    logic [spf_pkg::VIDX_W-1:0] ram_waddr, ram_raddr;
    logic [VW-1:0] ram_rdata;
    logic signed [CW-1:0] rd_x, rd_y;

    spf_pkg::div_req_t  div_req;
    spf_pkg::div_rsp_t  div_rsp;
    spf_pkg::sort_ctl_t sort_ctl;
    logic signed [spf_pkg::XING_W-1:0] head0, head1;
    logic [spf_pkg::VCNT_W-1:0] xcount;

    logic [spf_pkg::DIM_W-1:0] wid, hei;
    logic signed [17:0] y1e, y2e, yqe;
    logic crosses;
    logic signed [spf_pkg::XING_W-1:0] xing;
    logic [24:0] lo_sum;
    logic signed [17:0] lo_c, hi_c, lo_e, hi_e, wm1;
    logic span_ok;

    spf_ram #(.WIDTH(VW), .DEPTH(spf_pkg::MAX_VERTICES)) u_vtx_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({item.vertex_x, item.vertex_y}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    spf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    spf_xsort u_xsort (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sort_ctl),
        .head0 (head0),
        .head1 (head1),
        .count (xcount)
    );

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign out_free   = !out_valid_reg || span.ready;

    // RAM writes happen only in idle, where the read address stays at vertex 0
    assign ram_we    = accept && ((item.opcode == spf_pkg::OP_BEGIN) ||
                       ((item.opcode == spf_pkg::OP_ADD) &&
                        (vcount_reg < spf_pkg::VCNT_W'(spf_pkg::MAX_VERTICES))));
    assign ram_waddr = (item.opcode == spf_pkg::OP_BEGIN) ? '0
                                                          : vcount_reg[spf_pkg::VIDX_W-1:0];
    assign ram_raddr = (state_reg == S_IDLE) ? '0 : idx_reg + 1'b1;
    assign rd_x      = ram_rdata[VW-1:CW];
    assign rd_y      = ram_rdata[CW-1:0];

    assign wid = (width_reg > spf_pkg::DIM_W'(spf_pkg::MAX_DIM))
                 ? spf_pkg::DIM_W'(spf_pkg::MAX_DIM) : width_reg;
    assign hei = (height_reg > spf_pkg::DIM_W'(spf_pkg::MAX_DIM))
                 ? spf_pkg::DIM_W'(spf_pkg::MAX_DIM) : height_reg;

    // half-open crossing test against y = row
    assign y1e = {{2{y1_reg[CW-1]}}, y1_reg};
    assign y2e = {{2{y2_reg[CW-1]}}, y2_reg};
    assign yqe = {1'b0, yq_reg};
    assign crosses = ((y1e <= yqe) && (y2e > yqe)) || ((y1e > yqe) && (y2e <= yqe));

    assign xing = {{4{x1_reg[CW-1]}}, x1_reg, 4'b0000}
                + {{(spf_pkg::XING_W - spf_pkg::QUO_W){div_rsp.quo[spf_pkg::QUO_W-1]}},
                   div_rsp.quo};

    // span of the head pair: ceil of left, floor of right, clamped
    assign lo_sum = {head0[spf_pkg::XING_W-1], head0} + 25'd255;
    assign lo_e   = {lo_sum[24], lo_sum[24:8]};
    assign hi_e   = {{2{head1[spf_pkg::XING_W-1]}}, head1[spf_pkg::XING_W-1:8]};
    assign wm1    = $signed({5'd0, wid}) - 18'sd1;
    assign lo_c   = (lo_e < 18'sd0) ? 18'sd0 : lo_e;
    assign hi_c   = (hi_e > wm1) ? wm1 : hi_e;
    assign span_ok = (lo_c <= hi_c);

    always_comb
    begin
        state_next      = state_reg;
        vcount_next     = vcount_reg;
        ovf_next        = ovf_reg;
        yq_next         = yq_reg;
        idx_next        = idx_reg;
        closing_next    = closing_reg;
        fx_next         = fx_reg;
        fy_next         = fy_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        x1_next         = x1_reg;
        y1_next         = y1_reg;
        x2_next         = x2_reg;
        y2_next         = y2_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        den_next        = den_reg;
        held_valid_next = held_valid_reg;
        held_start_next = held_start_reg;
        held_end_next   = held_end_reg;
        push            = 1'b0;
        push_start      = held_start_reg;
        push_end        = held_end_reg;
        push_none       = 1'b0;
        push_last       = 1'b0;
        adv             = 1'b0;
        div_req.start   = 1'b0;
        div_req.num     = {prod_reg, 4'b0000};
        div_req.den     = den_reg;
        sort_ctl.clear  = 1'b0;
        sort_ctl.insert = 1'b0;
        sort_ctl.pop    = 1'b0;
        sort_ctl.value  = xing;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (item.opcode == spf_pkg::OP_BEGIN)
                    begin
                        vcount_next = spf_pkg::VCNT_W'(1);
                        ovf_next    = 1'b0;
                    end
                    else if (item.opcode == spf_pkg::OP_ADD)
                    begin
                        if (vcount_reg < spf_pkg::VCNT_W'(spf_pkg::MAX_VERTICES))
                        begin
                            vcount_next = vcount_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else if (item.opcode == spf_pkg::OP_RASTER)
                    begin
                        sort_ctl.clear  = 1'b1;
                        held_valid_next = 1'b0;
                        yq_next         = {1'b0, item.row, 4'b0000};
                        idx_next        = '0;
                        closing_next    = 1'b0;
                        if (({1'b0, item.row} < hei) && (vcount_reg != '0))
                        begin
                            state_next = S_FIRST;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FIRST:
            begin
                fx_next = rd_x;
                fy_next = rd_y;
                px_next = rd_x;
                py_next = rd_y;
                if (vcount_reg == spf_pkg::VCNT_W'(1))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                x1_next    = px_reg;
                y1_next    = py_reg;
                x2_next    = rd_x;
                y2_next    = rd_y;
                px_next    = rd_x;
                py_next    = rd_y;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (crosses)
                begin
                    dx_next    = {x2_reg[CW-1], x2_reg} - {x1_reg[CW-1], x1_reg};
                    dy_next    = yqe - y1e;
                    den_next   = {y2_reg[CW-1], y2_reg} - {y1_reg[CW-1], y1_reg};
                    state_next = S_MUL;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            S_MUL:
            begin
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                div_req.start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    sort_ctl.insert = 1'b1;
                    adv             = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (xcount >= spf_pkg::VCNT_W'(2))
                begin
                    // hold while an earlier span still waits for the buffer
                    if (!(span_ok && held_valid_reg && !out_free))
                    begin
                        sort_ctl.pop = 1'b1;
                        if (span_ok)
                        begin
                            push            = held_valid_reg;
                            held_valid_next = 1'b1;
                            held_start_next = lo_c[spf_pkg::COL_W-1:0];
                            held_end_next   = hi_c[spf_pkg::COL_W-1:0];
                        end
                    end
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    if (!held_valid_reg)
                    begin
                        push_none  = 1'b1;
                        push_start = '0;
                        push_end   = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // advance to the next edge, closing the polygon after the last vertex
        if (adv)
        begin
            priority if (closing_reg)
            begin
                state_next = S_EMIT;
            end
            else if ({1'b0, idx_reg} == vcount_reg - 1'b1)
            begin
                x1_next      = px_reg;
                y1_next      = py_reg;
                x2_next      = fx_reg;
                y2_next      = fy_reg;
                closing_next = 1'b1;
                state_next   = S_TEST;
            end
            else
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = S_LOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vcount_reg     <= '0;
            ovf_reg        <= 1'b0;
            width_reg      <= spf_pkg::DIM_W'(spf_pkg::MAX_DIM);
            height_reg     <= spf_pkg::DIM_W'(spf_pkg::MAX_DIM);
            fill_reg       <= '0;
            held_valid_reg <= 1'b0;
            closing_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            vcount_reg     <= vcount_next;
            ovf_reg        <= ovf_next;
            held_valid_reg <= held_valid_next;
            closing_reg    <= closing_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    spf_pkg::CFG_WIDTH:  width_reg  <= cfg_data[spf_pkg::DIM_W-1:0];
                    spf_pkg::CFG_HEIGHT: height_reg <= cfg_data[spf_pkg::DIM_W-1:0];
                    spf_pkg::CFG_FILL:   fill_reg   <= cfg_data;
                    default:             ;
                endcase
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (span.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        yq_reg         <= yq_next;
        idx_reg        <= idx_next;
        fx_reg         <= fx_next;
        fy_reg         <= fy_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        x1_reg         <= x1_next;
        y1_reg         <= y1_next;
        x2_reg         <= x2_next;
        y2_reg         <= y2_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        den_reg        <= den_next;
        prod_reg       <= dx_reg * dy_reg;
        held_start_reg <= held_start_next;
        held_end_reg   <= held_end_next;
        if (push)
        begin
            out_start_reg <= push_start;
            out_end_reg   <= push_end;
            out_fill_reg  <= fill_reg;
            out_none_reg  <= push_none;
            out_ovf_reg   <= ovf_reg;
            out_last_reg  <= push_last;
        end
    end

    assign span.valid           = out_valid_reg;
    assign span.span_start      = out_start_reg;
    assign span.span_end        = out_end_reg;
    assign span.fill_out        = out_fill_reg;
    assign span.no_span         = out_none_reg;
    assign span.vertex_overflow = out_ovf_reg;
    assign span.last_span       = out_last_reg;

`ifndef SYNTH
    a_vcount_cap: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= spf_pkg::VCNT_W'(spf_pkg::MAX_VERTICES))
        else $error("vertex count beyond capacity");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (vcount_reg == spf_pkg::VCNT_W'(spf_pkg::MAX_VERTICES)))
        else $error("overflow flagged with room in the store");

    a_xing_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (xcount <= vcount_reg))
        else $error("more crossings than edges");

    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        (span.valid && span.no_span) |-> span.last_span)
        else $error("empty-row result not marked last");
`endif

endmodule
